### rtl/core/via_pkg.sv
// Package for the versatile interface adapter core.
// Holds the transaction types, register map codes and control field codes.
// No dependencies.
package via_pkg;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [3:0] {
		REG_ORB    = 4'h0,
		REG_ORA    = 4'h1,
		REG_DDRB   = 4'h2,
		REG_DDRA   = 4'h3,
		REG_T1CL   = 4'h4,
		REG_T1CH   = 4'h5,
		REG_T1LL   = 4'h6,
		REG_T1LH   = 4'h7,
		REG_T2CL   = 4'h8,
		REG_T2CH   = 4'h9,
		REG_SR     = 4'ha,
		REG_ACR    = 4'hb,
		REG_PCR    = 4'hc,
		REG_IFR    = 4'hd,
		REG_IER    = 4'he,
		REG_ORA_NH = 4'hf
	} reg_addr_t;

	// shift register mode, ACR bits 4:2
	localparam logic [2:0] SR_T2_IN    = 3'b001;
	localparam logic [2:0] SR_SYS_IN   = 3'b010;
	localparam logic [2:0] SR_FREE_OUT = 3'b100;
	localparam logic [2:0] SR_T2_OUT   = 3'b101;
	localparam logic [2:0] SR_SYS_OUT  = 3'b110;

	// CA2 / CB2 control, PCR bits 3:1 and 7:5
	localparam logic [2:0] CTL_HAND  = 3'b100;
	localparam logic [2:0] CTL_PULSE = 3'b101;
	localparam logic [2:0] CTL_LOW   = 3'b110;

	localparam logic [6:0] FLAG_T1 = 7'h40;
	localparam logic [6:0] FLAG_T2 = 7'h20;
	localparam logic [6:0] FLAG_SR = 7'h04;

	localparam logic [3:0] SR_BITS_DONE = 4'd8;

	typedef struct packed {
		req_type_t req_type;
		reg_addr_t reg_addr;
		logic [7:0] write_data;
		logic       compare_in;
		logic [7:0] psg_read_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic [7:0] port_a_out;
		logic [7:0] port_b_out;
		logic       ca2_level;
		logic       cb2_hand_level;
		logic       cb2_shift_level;
		logic       pb7_timer;
	} result_t;

endpackage

### rtl/core/versatile_interface_adapter_core.sv
// Versatile interface adapter core: 6522-style ports, timers, shift register
// and interrupt logic behind a stream interface. One transaction in, one out.
// Depends on via_pkg and via_regs.
//
// Each input transaction (register read, register write or one peripheral
// clock tick) produces exactly one output transaction carrying the read byte
// and the current pin levels. A transaction is held in the input register
// and its result in the output register. All state updates for one
// transaction are done in a single pass of logic between the input register
// and the output register, so throughput is one transaction per clock
// whenever the output side keeps m_tready high.
module versatile_interface_adapter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // reg_addr[3:0], write_data[11:4], compare_in[12],
	                               // psg_read_data[20:13], zero[23:21]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // read_data[7:0], irq[8], port_a_out[16:9],
	                               // port_b_out[24:17], ca2_level[25], cb2_hand_level[26],
	                               // cb2_shift_level[27], pb7_timer[28], zero[31:29]
);
	import via_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	item_t   item_in;
	logic    m_valid_q;
	result_t res_q;
	result_t res;
	logic    adv;
	logic    en;
	logic    accept;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;
	assign en       = valid_s1 && adv;

	always_comb begin
		item_in.req_type      = req_type_t'(s_tuser);
		item_in.reg_addr      = reg_addr_t'(s_tdata[3:0]);
		item_in.write_data    = s_tdata[11:4];
		item_in.compare_in    = s_tdata[12];
		item_in.psg_read_data = s_tdata[20:13];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (en)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item_in;
		if (en)
			res_q <= res;
	end

	via_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.item   (item_s1),
		.result (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, res_q.pb7_timer, res_q.cb2_shift_level, res_q.cb2_hand_level,
		res_q.ca2_level, res_q.port_b_out, res_q.port_a_out, res_q.irq, res_q.read_data};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_issue_result: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> m_valid_q)
		else $error("processed transaction produced no result");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("pending transaction lost");

endmodule

### rtl/core/via_regs.sv
// Register file, timers, shift register and interrupt logic of the adapter.
// Applies one transaction per enabled cycle and returns its result.
// Depends on via_pkg.
module via_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  via_pkg::item_t  item,
	output via_pkg::result_t result
);
	import via_pkg::*;

	logic [7:0]  out_a_q, out_b_q, dir_a_q, dir_b_q;
	logic [15:0] t1_count_q;
	logic [7:0]  t1_latch_lo_q, t1_latch_hi_q;
	logic        t1_running_q, t1_armed_q, t1_pb7_q;
	logic [15:0] t2_count_q;
	logic [7:0]  t2_latch_lo_q;
	logic        t2_running_q, t2_armed_q;
	logic [7:0]  shift_reg_q;
	logic [3:0]  shift_bits_q;
	logic [7:0]  shift_div_q;
	logic        shift_phase_q;
	logic [7:0]  aux_ctrl_q, periph_ctrl_q;
	logic [6:0]  int_flags_q, int_enable_q;
	logic        ca2_q, cb2_hand_q, cb2_shift_q;

	logic [7:0]  out_a_d, out_b_d, dir_a_d, dir_b_d;
	logic [15:0] t1_count_d;
	logic [7:0]  t1_latch_lo_d, t1_latch_hi_d;
	logic        t1_running_d, t1_armed_d, t1_pb7_d;
	logic [15:0] t2_count_d;
	logic [7:0]  t2_latch_lo_d;
	logic        t2_running_d, t2_armed_d;
	logic [7:0]  shift_reg_d;
	logic [3:0]  shift_bits_d;
	logic [7:0]  shift_div_d;
	logic        shift_phase_d;
	logic [7:0]  aux_ctrl_d, periph_ctrl_d;
	logic [6:0]  int_flags_d, int_enable_d;
	logic        ca2_d, cb2_hand_d, cb2_shift_d;
	logic [7:0]  rd;
	logic [7:0]  port_a_val;
	logic        t2_pulse;
	logic        irq_q;

	assign irq_q      = |(int_flags_q & int_enable_q);
	assign port_a_val = (out_b_q[4:3] == 2'b01) ? item.psg_read_data : out_a_q;

	always_comb begin
		out_a_d       = out_a_q;
		out_b_d       = out_b_q;
		dir_a_d       = dir_a_q;
		dir_b_d       = dir_b_q;
		t1_count_d    = t1_count_q;
		t1_latch_lo_d = t1_latch_lo_q;
		t1_latch_hi_d = t1_latch_hi_q;
		t1_running_d  = t1_running_q;
		t1_armed_d    = t1_armed_q;
		t1_pb7_d      = t1_pb7_q;
		t2_count_d    = t2_count_q;
		t2_latch_lo_d = t2_latch_lo_q;
		t2_running_d  = t2_running_q;
		t2_armed_d    = t2_armed_q;
		shift_reg_d   = shift_reg_q;
		shift_bits_d  = shift_bits_q;
		shift_div_d   = shift_div_q;
		shift_phase_d = shift_phase_q;
		aux_ctrl_d    = aux_ctrl_q;
		periph_ctrl_d = periph_ctrl_q;
		int_flags_d   = int_flags_q;
		int_enable_d  = int_enable_q;
		ca2_d         = ca2_q;
		cb2_hand_d    = cb2_hand_q;
		cb2_shift_d   = cb2_shift_q;
		rd            = 8'd0;
		t2_pulse      = 1'b0;
		if (en) begin
			unique case (item.req_type)
				REQ_READ: begin
					unique case (item.reg_addr)
						REG_ORB: begin
							if (aux_ctrl_q[7])
								rd = {t1_pb7_q, out_b_q[6], item.compare_in, out_b_q[4:0]};
							else
								rd = {out_b_q[7:6], item.compare_in, out_b_q[4:0]};
						end
						REG_ORA: begin
							if (periph_ctrl_q[3:1] == CTL_HAND)
								ca2_d = 1'b0;
							rd = port_a_val;
						end
						REG_ORA_NH: rd = port_a_val;
						REG_DDRB:   rd = dir_b_q;
						REG_DDRA:   rd = dir_a_q;
						REG_T1CL: begin
							rd = t1_count_q[7:0];
							t1_running_d = 1'b0;
							t1_armed_d   = 1'b0;
							t1_pb7_d     = 1'b1;
							int_flags_d  = int_flags_q & ~FLAG_T1;
						end
						REG_T1CH: rd = t1_count_q[15:8];
						REG_T1LL: rd = t1_latch_lo_q;
						REG_T1LH: rd = t1_latch_hi_q;
						REG_T2CL: begin
							rd = t2_count_q[7:0];
							t2_running_d = 1'b0;
							t2_armed_d   = 1'b0;
							int_flags_d  = int_flags_q & ~FLAG_T2;
						end
						REG_T2CH: rd = t2_count_q[15:8];
						REG_SR: begin
							rd = shift_reg_q;
							shift_bits_d  = 4'd0;
							shift_phase_d = 1'b1;
							int_flags_d   = int_flags_q & ~FLAG_SR;
						end
						REG_ACR: rd = aux_ctrl_q;
						REG_PCR: rd = periph_ctrl_q;
						REG_IFR: rd = {irq_q, int_flags_q};
						REG_IER: rd = {1'b1, int_enable_q};
						default: rd = 8'd0;
					endcase
				end
				REQ_WRITE: begin
					unique case (item.reg_addr)
						REG_ORB: begin
							out_b_d = item.write_data;
							if (periph_ctrl_q[7:5] == CTL_HAND)
								cb2_hand_d = 1'b0;
						end
						REG_ORA: begin
							if (periph_ctrl_q[3:1] == CTL_HAND)
								ca2_d = 1'b0;
							out_a_d = item.write_data;
						end
						REG_ORA_NH: out_a_d = item.write_data;
						REG_DDRB:   dir_b_d = item.write_data;
						REG_DDRA:   dir_a_d = item.write_data;
						REG_T1CL, REG_T1LL: t1_latch_lo_d = item.write_data;
						REG_T1CH: begin
							t1_latch_hi_d = item.write_data;
							t1_count_d    = {item.write_data, t1_latch_lo_q};
							t1_running_d  = 1'b1;
							t1_armed_d    = 1'b1;
							t1_pb7_d      = 1'b0;
							int_flags_d   = int_flags_q & ~FLAG_T1;
						end
						REG_T1LH: t1_latch_hi_d = item.write_data;
						REG_T2CL: t2_latch_lo_d = item.write_data;
						REG_T2CH: begin
							t2_count_d   = {item.write_data, t2_latch_lo_q};
							t2_running_d = 1'b1;
							t2_armed_d   = 1'b1;
							int_flags_d  = int_flags_q & ~FLAG_T2;
						end
						REG_SR: begin
							shift_reg_d   = item.write_data;
							shift_bits_d  = 4'd0;
							shift_phase_d = 1'b1;
							int_flags_d   = int_flags_q & ~FLAG_SR;
						end
						REG_ACR: aux_ctrl_d = item.write_data;
						REG_PCR: begin
							periph_ctrl_d = item.write_data;
							ca2_d         = (item.write_data[3:1] != CTL_LOW);
							cb2_hand_d    = (item.write_data[7:5] != CTL_LOW);
						end
						REG_IFR: int_flags_d = int_flags_q & ~item.write_data[6:0];
						REG_IER: begin
							if (item.write_data[7])
								int_enable_d = int_enable_q | item.write_data[6:0];
							else
								int_enable_d = int_enable_q & ~item.write_data[6:0];
						end
						default: ;
					endcase
				end
				REQ_TICK: begin
					if (t1_running_q) begin
						t1_count_d = t1_count_q - 16'd1;
						if (t1_count_d == 16'hffff) begin
							if (aux_ctrl_q[6]) begin
								int_flags_d = int_flags_d | FLAG_T1;
								t1_pb7_d    = ~t1_pb7_q;
								t1_count_d  = {t1_latch_hi_q, t1_latch_lo_q};
							end else if (t1_armed_q) begin
								int_flags_d = int_flags_d | FLAG_T1;
								t1_pb7_d    = 1'b1;
								t1_armed_d  = 1'b0;
							end
						end
					end
					if (t2_running_q && !aux_ctrl_q[5]) begin
						t2_count_d = t2_count_q - 16'd1;
						if (t2_count_d == 16'hffff && t2_armed_q) begin
							int_flags_d = int_flags_d | FLAG_T2;
							t2_armed_d  = 1'b0;
						end
					end
					shift_div_d = shift_div_q - 8'd1;
					if (shift_div_d == 8'hff) begin
						shift_div_d   = t2_latch_lo_q;
						t2_pulse      = shift_phase_q;
						shift_phase_d = ~shift_phase_q;
					end
					if (shift_bits_q < SR_BITS_DONE) begin
						case (aux_ctrl_q[4:2])
							SR_T2_IN: begin
								if (t2_pulse) begin
									shift_reg_d  = {shift_reg_q[6:0], 1'b0};
									shift_bits_d = shift_bits_q + 4'd1;
								end
							end
							SR_SYS_IN: begin
								shift_reg_d  = {shift_reg_q[6:0], 1'b0};
								shift_bits_d = shift_bits_q + 4'd1;
							end
							SR_FREE_OUT: begin
								if (t2_pulse) begin
									cb2_shift_d = shift_reg_q[7];
									shift_reg_d = {shift_reg_q[6:0], shift_reg_q[7]};
								end
							end
							SR_T2_OUT: begin
								if (t2_pulse) begin
									cb2_shift_d  = shift_reg_q[7];
									shift_reg_d  = {shift_reg_q[6:0], shift_reg_q[7]};
									shift_bits_d = shift_bits_q + 4'd1;
								end
							end
							SR_SYS_OUT: begin
								cb2_shift_d  = shift_reg_q[7];
								shift_reg_d  = {shift_reg_q[6:0], shift_reg_q[7]};
								shift_bits_d = shift_bits_q + 4'd1;
							end
							default: ;
						endcase
						if (shift_bits_d == SR_BITS_DONE)
							int_flags_d = int_flags_d | FLAG_SR;
					end
					if (periph_ctrl_q[3:1] == CTL_PULSE)
						ca2_d = 1'b1;
					if (periph_ctrl_q[7:5] == CTL_PULSE)
						cb2_hand_d = 1'b1;
				end
				REQ_NONE: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		result.read_data       = rd;
		result.irq             = |(int_flags_d & int_enable_d);
		result.port_a_out      = out_a_d;
		result.port_b_out      = out_b_d;
		result.ca2_level       = ca2_d;
		result.cb2_hand_level  = cb2_hand_d;
		result.cb2_shift_level = cb2_shift_d;
		result.pb7_timer       = t1_pb7_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_a_q       <= '0;
			out_b_q       <= '0;
			dir_a_q       <= '0;
			dir_b_q       <= '0;
			t1_count_q    <= '0;
			t1_latch_lo_q <= '0;
			t1_latch_hi_q <= '0;
			t1_running_q  <= 1'b0;
			t1_armed_q    <= 1'b0;
			t1_pb7_q      <= 1'b1;
			t2_count_q    <= '0;
			t2_latch_lo_q <= '0;
			t2_running_q  <= 1'b0;
			t2_armed_q    <= 1'b0;
			shift_reg_q   <= '0;
			shift_bits_q  <= SR_BITS_DONE;
			shift_div_q   <= '0;
			shift_phase_q <= 1'b0;
			aux_ctrl_q    <= '0;
			periph_ctrl_q <= '0;
			int_flags_q   <= '0;
			int_enable_q  <= '0;
			ca2_q         <= 1'b1;
			cb2_hand_q    <= 1'b1;
			cb2_shift_q   <= 1'b0;
		end else begin
			out_a_q       <= out_a_d;
			out_b_q       <= out_b_d;
			dir_a_q       <= dir_a_d;
			dir_b_q       <= dir_b_d;
			t1_count_q    <= t1_count_d;
			t1_latch_lo_q <= t1_latch_lo_d;
			t1_latch_hi_q <= t1_latch_hi_d;
			t1_running_q  <= t1_running_d;
			t1_armed_q    <= t1_armed_d;
			t1_pb7_q      <= t1_pb7_d;
			t2_count_q    <= t2_count_d;
			t2_latch_lo_q <= t2_latch_lo_d;
			t2_running_q  <= t2_running_d;
			t2_armed_q    <= t2_armed_d;
			shift_reg_q   <= shift_reg_d;
			shift_bits_q  <= shift_bits_d;
			shift_div_q   <= shift_div_d;
			shift_phase_q <= shift_phase_d;
			aux_ctrl_q    <= aux_ctrl_d;
			periph_ctrl_q <= periph_ctrl_d;
			int_flags_q   <= int_flags_d;
			int_enable_q  <= int_enable_d;
			ca2_q         <= ca2_d;
			cb2_hand_q    <= cb2_hand_d;
			cb2_shift_q   <= cb2_shift_d;
		end
	end

	a_sr_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_bits_q <= SR_BITS_DONE)
		else $error("shift bit count beyond a full byte");

	a_t1_start: assert property (@(posedge clk) disable iff (!arst_n)
		(en && item.req_type == REQ_WRITE && item.reg_addr == REG_T1CH)
		|=> (t1_running_q && t1_armed_q && !t1_pb7_q && !int_flags_q[6]))
		else $error("timer 1 did not start on high counter write");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(int_flags_q) && $stable(t1_count_q) && $stable(shift_reg_q)))
		else $error("state changed without a transaction");

endmodule

### tb/sv/tb_versatile_interface_adapter_core.sv
// Self-checking testbench for versatile_interface_adapter_core.
// Checks every output transaction against a cycle-free predictor of the adapter
// state, or a directed row's pins. Depends on via_pkg and the core RTL only.
module tb_versatile_interface_adapter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import via_pkg::*;

	localparam int RAND_PER_PHASE = 134;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam result_t NO_PINS   = '0;

	typedef struct packed {
		req_type_t  req;
		reg_addr_t  addr;
		logic [7:0] wd;
		logic       cmp;
		logic [7:0] psg;
		logic       typed;
		result_t    pins;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	// sideband registered along with each offered transaction
	logic        row_typed;
	result_t     row_expect;

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int stall_cycles = 0;
	int n_errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_ticks = 0;
	int n_reads = 0;
	int n_writes = 0;
	int t1_fires = 0;
	int t2_fires = 0;
	int sr_fills = 0;
	int irq_high = 0;

	result_t expected_pins_q[$];

	// predicted adapter state, reset values
	logic [7:0]  ora = '0, orb = '0, ddra = '0, ddrb = '0;
	logic [15:0] t1_cnt = '0, t2_cnt = '0;
	logic [7:0]  t1_lat_lo = '0, t1_lat_hi = '0, t2_lat_lo = '0;
	logic        t1_run = 1'b0, t1_live = 1'b0, t1_pb7 = 1'b1;
	logic        t2_run = 1'b0, t2_live = 1'b0;
	logic [7:0]  sr = '0, sr_div = '0, acr = '0, pcr = '0, ifr = '0;
	logic [3:0]  sr_cnt = SR_BITS_DONE;
	logic        sr_phase = 1'b0;
	logic [6:0]  ier = '0;
	logic        ca2 = 1'b1, cb2_hand = 1'b1, cb2_shift = 1'b0;

	dir_row_t dir_rows[26] = '{
		'{REQ_READ,  REG_IER,    8'h00, 1'b0, 8'h00, 1'b1,
			'{8'h80, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_READ,  REG_ORB,    8'h00, 1'b1, 8'hff, 1'b1,
			'{8'h20, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_NONE,  REG_ORA_NH, 8'hff, 1'b1, 8'hff, 1'b1,
			'{8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_WRITE, REG_ORA,    8'hff, 1'b0, 8'h00, 1'b1,
			'{8'h00, 1'b0, 8'hff, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_WRITE, REG_ORB,    8'h08, 1'b0, 8'h00, 1'b1,
			'{8'h00, 1'b0, 8'hff, 8'h08, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_READ,  REG_ORA,    8'h00, 1'b0, 8'ha5, 1'b1,
			'{8'ha5, 1'b0, 8'hff, 8'h08, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_READ,  REG_ORA_NH, 8'h00, 1'b0, 8'h3c, 1'b1,
			'{8'h3c, 1'b0, 8'hff, 8'h08, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_WRITE, REG_ORB,    8'hff, 1'b0, 8'h00, 1'b1,
			'{8'h00, 1'b0, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_READ,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b1,
			'{8'hdf, 1'b0, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0, 1'b1}},
		'{REQ_WRITE, REG_IER,    8'hff, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_T1CH,   8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_READ,  REG_T1CL,   8'h00, 1'b1, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_T2CH,   8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_ACR,    8'hd8, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_SR,     8'h81, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_PCR,    8'hcc, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_PCR,    8'haa, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_PCR,    8'h88, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_READ,  REG_ORA,    8'h00, 1'b1, 8'h5a, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_IFR,    8'hff, 1'b0, 8'h00, 1'b0, NO_PINS},
		'{REQ_WRITE, REG_IER,    8'h7f, 1'b0, 8'h00, 1'b0, NO_PINS}
	};

	versatile_interface_adapter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	function automatic void ifr_update(input logic [6:0] set_bits, input logic [6:0] clr_bits);
		ifr[6:0] = (ifr[6:0] | set_bits) & ~clr_bits;
		ifr[7] = |(ifr[6:0] & ier);
	endfunction

	function automatic result_t via_predict(input req_type_t req, input logic [23:0] d);
		reg_addr_t  addr;
		logic [7:0] wd, psg, rd, pa_in;
		logic       cmp, t2_pulse, shift_en, rotate, counted;
		result_t    r;
		addr = reg_addr_t'(d[3:0]);
		wd = d[11:4];
		cmp = d[12];
		psg = d[20:13];
		rd = '0;
		pa_in = (orb[4:3] == 2'b01) ? psg : ora;
		case (req)
		REQ_READ: begin
			n_reads++;
			case (addr)
			REG_ORB: rd = acr[7] ? {t1_pb7, orb[6], cmp, orb[4:0]} : {orb[7:6], cmp, orb[4:0]};
			REG_ORA: begin
				if (pcr[3:1] == CTL_HAND)
					ca2 = 1'b0;
				rd = pa_in;
			end
			REG_ORA_NH: rd = pa_in;
			REG_DDRB: rd = ddrb;
			REG_DDRA: rd = ddra;
			REG_T1CL: begin
				rd = t1_cnt[7:0];
				t1_run = 1'b0;
				t1_live = 1'b0;
				t1_pb7 = 1'b1;
				ifr_update('0, FLAG_T1);
			end
			REG_T1CH: rd = t1_cnt[15:8];
			REG_T1LL: rd = t1_lat_lo;
			REG_T1LH: rd = t1_lat_hi;
			REG_T2CL: begin
				rd = t2_cnt[7:0];
				t2_run = 1'b0;
				t2_live = 1'b0;
				ifr_update('0, FLAG_T2);
			end
			REG_T2CH: rd = t2_cnt[15:8];
			REG_SR: begin
				rd = sr;
				sr_cnt = '0;
				sr_phase = 1'b1;
				ifr_update('0, FLAG_SR);
			end
			REG_ACR: rd = acr;
			REG_PCR: rd = pcr;
			REG_IFR: rd = ifr;
			REG_IER: rd = {1'b1, ier};
			endcase
		end
		REQ_WRITE: begin
			n_writes++;
			case (addr)
			REG_ORB: begin
				orb = wd;
				if (pcr[7:5] == CTL_HAND)
					cb2_hand = 1'b0;
			end
			REG_ORA: begin
				if (pcr[3:1] == CTL_HAND)
					ca2 = 1'b0;
				ora = wd;
			end
			REG_ORA_NH: ora = wd;
			REG_DDRB: ddrb = wd;
			REG_DDRA: ddra = wd;
			REG_T1CL, REG_T1LL: t1_lat_lo = wd;
			REG_T1CH: begin
				t1_lat_hi = wd;
				t1_cnt = {wd, t1_lat_lo};
				t1_run = 1'b1;
				t1_live = 1'b1;
				t1_pb7 = 1'b0;
				ifr_update('0, FLAG_T1);
			end
			REG_T1LH: t1_lat_hi = wd;
			REG_T2CL: t2_lat_lo = wd;
			REG_T2CH: begin
				t2_cnt = {wd, t2_lat_lo};
				t2_run = 1'b1;
				t2_live = 1'b1;
				ifr_update('0, FLAG_T2);
			end
			REG_SR: begin
				sr = wd;
				sr_cnt = '0;
				sr_phase = 1'b1;
				ifr_update('0, FLAG_SR);
			end
			REG_ACR: acr = wd;
			REG_PCR: begin
				pcr = wd;
				ca2 = (wd[3:1] != CTL_LOW);
				cb2_hand = (wd[7:5] != CTL_LOW);
			end
			REG_IFR: ifr_update('0, wd[6:0]);
			REG_IER: begin
				if (wd[7])
					ier = ier | wd[6:0];
				else
					ier = ier & ~wd[6:0];
				ifr_update('0, '0);
			end
			endcase
		end
		REQ_TICK: begin
			n_ticks++;
			if (t1_run) begin
				t1_cnt = t1_cnt - 16'd1;
				if (t1_cnt == 16'hffff) begin
					if (acr[6]) begin
						ifr_update(FLAG_T1, '0);
						t1_pb7 = ~t1_pb7;
						t1_cnt = {t1_lat_hi, t1_lat_lo};
						t1_fires++;
					end else if (t1_live) begin
						ifr_update(FLAG_T1, '0);
						t1_pb7 = 1'b1;
						t1_live = 1'b0;
						t1_fires++;
					end
				end
			end
			if (t2_run && !acr[5]) begin
				t2_cnt = t2_cnt - 16'd1;
				if (t2_cnt == 16'hffff && t2_live) begin
					ifr_update(FLAG_T2, '0);
					t2_live = 1'b0;
					t2_fires++;
				end
			end
			t2_pulse = 1'b0;
			sr_div = sr_div - 8'd1;
			if (sr_div == 8'hff) begin
				sr_div = t2_lat_lo;
				t2_pulse = sr_phase;
				sr_phase = ~sr_phase;
			end
			if (sr_cnt < SR_BITS_DONE) begin
				shift_en = 1'b0;
				rotate = 1'b0;
				counted = 1'b1;
				case (acr[4:2])
				SR_T2_IN: shift_en = t2_pulse;
				SR_SYS_IN: shift_en = 1'b1;
				SR_FREE_OUT: begin
					shift_en = t2_pulse;
					rotate = 1'b1;
					counted = 1'b0;
				end
				SR_T2_OUT: begin
					shift_en = t2_pulse;
					rotate = 1'b1;
				end
				SR_SYS_OUT: begin
					shift_en = 1'b1;
					rotate = 1'b1;
				end
				default: ;
				endcase
				if (shift_en) begin
					if (rotate) begin
						cb2_shift = sr[7];
						sr = {sr[6:0], sr[7]};
					end else begin
						sr = {sr[6:0], 1'b0};
					end
					if (counted)
						sr_cnt = sr_cnt + 4'd1;
				end
				if (sr_cnt == SR_BITS_DONE) begin
					ifr_update(FLAG_SR, '0);
					sr_fills++;
				end
			end
			if (pcr[3:1] == CTL_PULSE)
				ca2 = 1'b1;
			if (pcr[7:5] == CTL_PULSE)
				cb2_hand = 1'b1;
		end
		default: ;
		endcase
		r.read_data = rd;
		r.irq = ifr[7];
		r.port_a_out = ora;
		r.port_b_out = orb;
		r.ca2_level = ca2;
		r.cb2_hand_level = cb2_hand;
		r.cb2_shift_level = cb2_shift;
		r.pb7_timer = t1_pb7;
		return r;
	endfunction

	function automatic string pins_str(input result_t p);
		return $sformatf("rd=%h irq=%b pa=%h pb=%h ca2=%b cb2h=%b cb2s=%b pb7=%b",
			p.read_data, p.irq, p.port_a_out, p.port_b_out, p.ca2_level,
			p.cb2_hand_level, p.cb2_shift_level, p.pb7_timer);
	endfunction

	task automatic flag_error(input string what, input result_t want, input result_t got);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t %s: expected %s / got %s", $realtime, what, pins_str(want), pins_str(got));
	endtask

	// timer reloads are kept short most of the time so the timers actually expire
	function automatic item_t rand_item();
		item_t it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		it.reg_addr = reg_addr_t'($urandom_range(0, 15));
		it.write_data = 8'($urandom_range(0, 255));
		it.compare_in = 1'($urandom_range(0, 1));
		it.psg_read_data = 8'($urandom_range(0, 255));
		if (pick < 50) begin
			it.req_type = REQ_TICK;
		end else if (pick < 70) begin
			it.req_type = REQ_READ;
		end else if (pick < 73) begin
			it.req_type = REQ_NONE;
		end else begin
			it.req_type = REQ_WRITE;
			if ($urandom_range(0, 3) != 0) begin
				case (it.reg_addr)
				REG_T1CL, REG_T1LL, REG_T2CL: it.write_data = 8'($urandom_range(0, 6));
				REG_T1CH, REG_T1LH, REG_T2CH: it.write_data = 8'h00;
				default: ;
				endcase
			end
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, input logic typed, input result_t pins);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.req_type;
		s_tdata <= {3'b000, it.psg_read_data, it.compare_in, it.write_data, it.reg_addr};
		row_typed <= typed;
		row_expect <= pins;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	always @(posedge clk) begin
		result_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = via_predict(req_type_t'(s_tuser), s_tdata);
				if (row_typed)
					want = row_expect;
				expected_pins_q.push_back(want);
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				got.read_data = m_tdata[7:0];
				got.irq = m_tdata[8];
				got.port_a_out = m_tdata[16:9];
				got.port_b_out = m_tdata[24:17];
				got.ca2_level = m_tdata[25];
				got.cb2_hand_level = m_tdata[26];
				got.cb2_shift_level = m_tdata[27];
				got.pb7_timer = m_tdata[28];
				n_out++;
				if (got.irq === 1'b1)
					irq_high++;
				if (expected_pins_q.size() == 0) begin
					flag_error("unexpected transaction", NO_PINS, got);
				end else begin
					want = expected_pins_q.pop_front();
					if (got.read_data !== want.read_data || got.irq !== want.irq
						|| got.port_a_out !== want.port_a_out
						|| got.port_b_out !== want.port_b_out
						|| got.ca2_level !== want.ca2_level
						|| got.cb2_hand_level !== want.cb2_hand_level
						|| got.cb2_shift_level !== want.cb2_shift_level
						|| got.pb7_timer !== want.pb7_timer)
						flag_error("mismatch", want, got);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_versatile_interface_adapter_core failed");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin
		item_t it;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		row_typed = 1'b0;
		row_expect = NO_PINS;
		tx_idle_pct = 13;
		rx_idle_pct = 52;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			it.req_type = dir_rows[i].req;
			it.reg_addr = dir_rows[i].addr;
			it.write_data = dir_rows[i].wd;
			it.compare_in = dir_rows[i].cmp;
			it.psg_read_data = dir_rows[i].psg;
			send_item(it, dir_rows[i].typed, dir_rows[i].pins);
		end
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
			0: begin
				tx_idle_pct = 13;
				rx_idle_pct = 52;
			end
			1: begin
				tx_idle_pct = 52;
				rx_idle_pct = 13;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_request = 1'b1;
			end
			endcase
			repeat (RAND_PER_PHASE) send_item(rand_item(), 1'b0, NO_PINS);
		end
		s_tvalid <= 1'b0;
		while (expected_pins_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d transactions in, %0d out: %0d ticks, %0d reads, %0d writes",
			n_in, n_out, n_ticks, n_reads, n_writes);
		$display("timer 1 fired %0d, timer 2 fired %0d, shift done %0d, irq high in %0d results",
			t1_fires, t2_fires, sr_fills, irq_high);
		if (n_errors == 0)
			$display("tb_versatile_interface_adapter_core passed");
		else
			$display("tb_versatile_interface_adapter_core failed");
		$finish;
	end

endmodule
